// ===== hdl/awfe_pkg.sv =====
// Shared constants for the window feature extractor.
`timescale 1ns / 1ps
package awfe_pkg;

  localparam int WindowDepth = 512;
  localparam int AddrW       = $clog2(WindowDepth);
  localparam int SampleW     = 16;
  localparam int FeatW       = 24;
  localparam int NumRegs     = 6;
  localparam int PaddrW      = 5;

  // Sums over the window: signed sample sum and unsigned square sum.
  localparam int SumW   = SampleW + AddrW + 1;
  localparam int SqSumW = 2 * SampleW + AddrW;
  // Spread N*sum(v^2) - (sum v)^2 fits in this many bits.
  localparam int SpreadW = 2 * SumW;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegMeanA   = 3'd0;
  localparam logic [2:0] RegMeanB   = 3'd1;
  localparam logic [2:0] RegMeanMag = 3'd2;
  localparam logic [2:0] RegScaleA  = 3'd3;
  localparam logic [2:0] RegScaleB  = 3'd4;
  localparam logic [2:0] RegScaleM  = 3'd5;

  localparam logic [31:0] MeanAReset   = 32'd34080536;
  localparam logic [31:0] MeanBReset   = 32'd32047901;
  localparam logic [15:0] MeanMagReset = 16'd476;
  localparam logic [31:0] ScaleAReset  = 32'd580980072;
  localparam logic [31:0] ScaleBReset  = 32'd1019550414;
  localparam logic [15:0] ScaleMReset  = 16'd10446;

endpackage

// ===== hdl/awfe_stream_if.sv =====
// Valid/ready channel interfaces for samples and feature results.
`timescale 1ns / 1ps
interface awfe_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface awfe_feature_if;
  logic               valid;
  logic               ready;
  logic               window_ready;
  logic signed [23:0] feat_min_magnitude;
  logic signed [23:0] feat_std_z;
  logic signed [23:0] feat_std_y;
  logic signed [23:0] feat_std_x;
  logic signed [23:0] feat_mean_magnitude;
  modport source (output valid, window_ready, feat_min_magnitude, feat_std_z,
                  feat_std_y, feat_std_x, feat_mean_magnitude, input ready);
  modport sink   (input valid, window_ready, feat_min_magnitude, feat_std_z,
                  feat_std_y, feat_std_x, feat_mean_magnitude, output ready);
endinterface

// ===== hdl/awfe_isqrt.sv =====
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module awfe_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [awfe_pkg::SpreadW-1:0] radicand,
  output logic                         done,
  output logic [awfe_pkg::SpreadW/2-1:0] root
);
  import awfe_pkg::*;

  localparam int RootW = SpreadW / 2;
  localparam int CntW  = $clog2(RootW + 1);

  logic [SpreadW-1:0] rem_q;
  logic [SpreadW-1:0] rad_q;
  logic [RootW-1:0]   res_q;
  logic [CntW-1:0]    cnt;
  logic               busy;
  logic [SpreadW+1:0] trial;
  logic [SpreadW+1:0] rem_shift;

  // One restoring step: bring down two bits, try subtracting 4*root+1.
  assign rem_shift = {rem_q, rad_q[SpreadW-1 -: 2]};
  assign trial     = rem_shift - {{(SpreadW-RootW){1'b0}}, res_q, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        rem_q <= '0;
        rad_q <= radicand;
        res_q <= '0;
        cnt   <= CntW'(RootW);
      end else if (busy) begin
        rad_q <= {rad_q[SpreadW-3:0], 2'b00};
        if (!trial[SpreadW+1]) begin
          rem_q <= trial[SpreadW-1:0];
          res_q <= {res_q[RootW-2:0], 1'b1};
        end else begin
          rem_q <= rem_shift[SpreadW-1:0];
          res_q <= {res_q[RootW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = res_q;
endmodule

// ===== hdl/accel_window_feature_extractor.sv =====
// Top level of the sliding-window accelerometer feature extractor.
`timescale 1ns / 1ps
// Each accepted sample is held, then ST_MAG starts the magnitude root. All 512
// window-memory rows are then read through the single read port, one entry per
// cycle, and the read and square stages drain. Four square roots run on a
// shared bit-serial unit of 26 steps: one for the magnitude and one for each
// standard deviation after its spread setup. Standardization runs through one
// multiplier, feature by feature, in ST_FEAT, ST_FEAT_MUL and ST_OUT. The
// window memory is zeroed by a clearing pass over all 512 rows after reset,
// during which no sample is taken. Results sit in an output register, so a
// sample can be taken while the last result waits; the next result waits until
// that one is taken.
module accel_window_feature_extractor (
  input  logic                 clk,
  input  logic                 rst,
  awfe_sample_if.sink          samp,
  awfe_feature_if.source       feat,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [awfe_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import awfe_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MAG, ST_MAG_WAIT, ST_WRITE, ST_SCAN,
    ST_SPREAD, ST_ROOT, ST_ROOT_WAIT, ST_STD, ST_FEAT, ST_FEAT_MUL, ST_OUT
  } state_t;

  // Configuration registers.
  logic [31:0] mean_a, mean_b, scale_a, scale_b;
  logic [15:0] mean_m, scale_m;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_a  <= MeanAReset;
      mean_b  <= MeanBReset;
      mean_m  <= MeanMagReset;
      scale_a <= ScaleAReset;
      scale_b <= ScaleBReset;
      scale_m <= ScaleMReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegMeanA:   mean_a  <= pwdata;
        RegMeanB:   mean_b  <= pwdata;
        RegMeanMag: mean_m  <= pwdata[15:0];
        RegScaleA:  scale_a <= pwdata;
        RegScaleB:  scale_b <= pwdata;
        RegScaleM:  scale_m <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      RegMeanA:   prdata = mean_a;
      RegMeanB:   prdata = mean_b;
      RegMeanMag: prdata = {16'd0, mean_m};
      RegScaleA:  prdata = scale_a;
      RegScaleB:  prdata = scale_b;
      RegScaleM:  prdata = {16'd0, scale_m};
      default:    prdata = '0;
    endcase
  end

  // Window memory: one 64-bit row holds magnitude, z, y and x.
  logic [63:0]      win_mem [WindowDepth];
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [63:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [63:0]      mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) win_mem[mem_waddr] <= mem_wdata;
    mem_rdata <= win_mem[mem_raddr];
  end

  // Control and datapath registers.
  state_t           state;
  logic [AddrW-1:0] wptr;
  logic [AddrW-1:0] ptr;
  logic             filled;
  logic             rd_valid;
  logic             rd_valid_q;
  logic             scan_last_q;
  logic signed [15:0] sx, sy, sz;
  logic [15:0]      mag;
  logic [15:0]      min_mag;
  logic [SumW-1:0]  sum_mag;
  logic signed [SumW-1:0] sum_x, sum_y, sum_z;
  logic [SqSumW-1:0] sq_x, sq_y, sq_z;
  logic [1:0]       axis;
  logic [SpreadW-1:0] spread;
  logic [15:0]      std_x, std_y, std_z;
  logic [2:0]       fidx;
  logic signed [16:0] diff;
  logic [15:0]      fscale;
  logic signed [33:0] prod;
  logic             sample_held;

  // Shared square-root unit.
  logic               sq_start;
  logic [SpreadW-1:0] sq_rad;
  logic               sq_done;
  logic [SpreadW/2-1:0] sq_root;

  awfe_isqrt u_isqrt (
    .clk, .rst, .start(sq_start), .radicand(sq_rad), .done(sq_done), .root(sq_root)
  );

  // Row fields read back from memory.
  logic signed [15:0] rx, ry, rz;
  logic [15:0]        rm;
  assign rx = mem_rdata[15:0];
  assign ry = mem_rdata[31:16];
  assign rz = mem_rdata[47:32];
  assign rm = mem_rdata[63:48];

  // Squares formed in a stage of their own from the read data.
  logic [31:0]  px, py, pz;
  logic [15:0]  rm_q;
  logic signed [15:0] rx_q, ry_q, rz_q;
  logic         sq_valid;

  // Selected axis for the spread computation.
  logic signed [SumW-1:0] sel_sum;
  logic [SqSumW-1:0]      sel_sq;
  logic [SumW-1:0]        abs_sum;
  always_comb begin
    case (axis)
      2'd0:    begin sel_sum = sum_z; sel_sq = sq_z; end
      2'd1:    begin sel_sum = sum_y; sel_sq = sq_y; end
      default: begin sel_sum = sum_x; sel_sq = sq_x; end
    endcase
    abs_sum = sel_sum[SumW-1] ? SumW'(-sel_sum) : SumW'(sel_sum);
  end

  // Spread terms: N times the square sum, and the squared sample sum.
  logic [SpreadW-1:0] sq_scaled;
  logic [SpreadW-1:0] sum_sq;
  assign sq_scaled = SpreadW'(sel_sq) << AddrW;
  assign sum_sq    = SpreadW'(abs_sum) * SpreadW'(abs_sum);

  // Squared components of the held sample for its magnitude.
  logic [31:0] mx2, my2, mz2;
  assign mx2 = 32'(sx) * 32'(sx);
  assign my2 = 32'(sy) * 32'(sy);
  assign mz2 = 32'(sz) * 32'(sz);

  // Feature operands.
  logic [15:0] f_raw, f_mean;
  always_comb begin
    case (fidx)
      3'd0:    begin f_raw = min_mag; f_mean = mean_a[15:0];  fscale = scale_a[15:0];  end
      3'd1:    begin f_raw = std_z;   f_mean = mean_a[31:16]; fscale = scale_a[31:16]; end
      3'd2:    begin f_raw = std_y;   f_mean = mean_b[15:0];  fscale = scale_b[15:0];  end
      3'd3:    begin f_raw = std_x;   f_mean = mean_b[31:16]; fscale = scale_b[31:16]; end
      default: begin
        f_raw  = sum_mag[SumW-2 -: 16];
        f_mean = mean_m;
        fscale = scale_m;
      end
    endcase
  end

  // Round to Q.12 and saturate.
  logic signed [24:0] rounded;
  logic signed [FeatW-1:0] sat;
  assign rounded = 25'((prod + 34'sd512) >>> 10);
  always_comb begin
    if (rounded > 25'sd8388607)       sat = 24'sh7FFFFF;
    else if (rounded < -25'sd8388608) sat = 24'sh800000;
    else                              sat = rounded[FeatW-1:0];
  end

  logic [FeatW-1:0] res_min, res_z, res_y, res_x, res_mean;

  assign samp.ready = (state == ST_IDLE) && !sample_held;
  // The root unit samples its radicand in the cycle after ST_MAG raises start.
  assign sq_rad = (state == ST_MAG_WAIT) ?
                  SpreadW'(mx2) + SpreadW'(my2) + SpreadW'(mz2) : spread;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      wptr       <= '0;
      ptr        <= '0;
      filled     <= 1'b0;
      feat.valid <= 1'b0;
      mem_we     <= 1'b0;
      rd_valid   <= 1'b0;
      rd_valid_q <= 1'b0;
      sq_valid   <= 1'b0;
      sq_start   <= 1'b0;
      sample_held <= 1'b0;
    end else begin
      mem_we   <= 1'b0;
      sq_start <= 1'b0;
      rd_valid <= 1'b0;
      rd_valid_q <= rd_valid;
      sq_valid <= rd_valid_q;
      scan_last_q  <= 1'b0;
      if (feat.valid && feat.ready) feat.valid <= 1'b0;
      px <= 32'(rx) * 32'(rx);
      py <= 32'(ry) * 32'(ry);
      pz <= 32'(rz) * 32'(rz);
      rm_q <= rm; rx_q <= rx; ry_q <= ry; rz_q <= rz;

      unique case (state)
        // Zero the window after reset, one row a cycle.
        ST_CLEAR: begin
          mem_we    <= 1'b1;
          mem_waddr <= ptr;
          mem_wdata <= '0;
          ptr       <= ptr + 1'b1;
          if (ptr == AddrW'(WindowDepth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (samp.valid && samp.ready) begin
            sx <= samp.accel_x;
            sy <= samp.accel_y;
            sz <= samp.accel_z;
            sample_held <= 1'b1;
          end
          if (sample_held && !feat.valid) begin
            sample_held <= 1'b0;
            state <= ST_MAG;
          end
        end
        ST_MAG: begin
          sq_start <= 1'b1;
          state    <= ST_MAG_WAIT;
        end
        ST_MAG_WAIT: begin
          if (sq_done) begin
            mag   <= sq_root[15:0];
            state <= ST_WRITE;
          end
        end
        // Store the new row, then walk the window.
        ST_WRITE: begin
          mem_we    <= 1'b1;
          mem_waddr <= wptr;
          mem_wdata <= {mag, sz, sy, sx};
          wptr      <= wptr + 1'b1;
          if (wptr == AddrW'(WindowDepth - 1)) filled <= 1'b1;
          ptr     <= '0;
          min_mag <= 16'hFFFF;
          sum_mag <= '0;
          sum_x <= '0; sum_y <= '0; sum_z <= '0;
          sq_x  <= '0; sq_y  <= '0; sq_z  <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (ptr != AddrW'(WindowDepth - 1) || !scan_last_q) begin
            mem_raddr <= ptr;
            rd_valid  <= 1'b1;
            ptr       <= ptr + 1'b1;
            if (ptr == AddrW'(WindowDepth - 1)) begin
              scan_last_q <= 1'b1;
              state       <= ST_SPREAD;
            end
          end
        end
        ST_SPREAD: begin
          // Drain the address, read and square stages before forming the spread.
          if (!rd_valid && !rd_valid_q && !sq_valid) begin
            axis  <= 2'd0;
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          spread <= (sq_scaled > sum_sq) ? sq_scaled - sum_sq : '0;
          state <= ST_STD;
        end
        ST_STD: begin
          sq_start <= 1'b1;
          state    <= ST_ROOT_WAIT;
        end
        ST_ROOT_WAIT: begin
          if (sq_done) begin
            case (axis)
              2'd0:    std_z <= 16'(sq_root >> AddrW);
              2'd1:    std_y <= 16'(sq_root >> AddrW);
              default: std_x <= 16'(sq_root >> AddrW);
            endcase
            if (axis == 2'd2) begin
              fidx  <= '0;
              state <= ST_FEAT;
            end else begin
              axis  <= axis + 1'b1;
              state <= ST_ROOT;
            end
          end
        end
        ST_FEAT: begin
          diff  <= $signed({1'b0, f_raw}) - $signed({1'b0, f_mean});
          state <= ST_FEAT_MUL;
        end
        ST_FEAT_MUL: begin
          prod  <= diff * $signed({1'b0, fscale});
          state <= ST_OUT;
        end
        ST_OUT: begin
          case (fidx)
            3'd0:    res_min  <= sat;
            3'd1:    res_z    <= sat;
            3'd2:    res_y    <= sat;
            3'd3:    res_x    <= sat;
            default: res_mean <= sat;
          endcase
          if (fidx == 3'd4) begin
            feat.valid <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            fidx  <= fidx + 1'b1;
            state <= ST_FEAT;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // Accumulate over the squared stage.
      if (sq_valid) begin
        sum_mag <= sum_mag + SumW'(rm_q);
        if (rm_q < min_mag) min_mag <= rm_q;
        sum_x <= sum_x + SumW'(rx_q);
        sum_y <= sum_y + SumW'(ry_q);
        sum_z <= sum_z + SumW'(rz_q);
        sq_x  <= sq_x + SqSumW'(px);
        sq_y  <= sq_y + SqSumW'(py);
        sq_z  <= sq_z + SqSumW'(pz);
      end
    end
  end

  assign feat.window_ready        = filled;
  assign feat.feat_min_magnitude  = res_min;
  assign feat.feat_std_z          = res_z;
  assign feat.feat_std_y          = res_y;
  assign feat.feat_std_x          = res_x;
  assign feat.feat_mean_magnitude = res_mean;
endmodule

// ===== hdl/awfe_checker.sv =====
// Port-level checks for the window feature extractor, bound to the top level.
`timescale 1ns / 1ps
module awfe_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic window_ready,
  input logic pready
);
  // A result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // No result appears directly after a sample is taken.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid)) else $error("result too early");

  // Once the window fills, the flag never drops until reset.
  a_filled: assert property (@(posedge clk) disable iff (rst)
    window_ready |=> window_ready) else $error("window flag dropped");

  // No sample is accepted in the cycle right after a sample.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("sample taken while busy");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind accel_window_feature_extractor awfe_checker u_awfe_checker (
  .clk(clk), .rst(rst),
  .in_valid(samp.valid), .in_ready(samp.ready),
  .out_valid(feat.valid), .out_ready(feat.ready),
  .window_ready(feat.window_ready), .pready(pready)
);
